// ===== hw/rtl/fsa_pkg.sv =====
// ----------------------------------------------------------------------------
// fsa_pkg
// Shared types and constants of the fixed slot allocator.
// ----------------------------------------------------------------------------
package fsa_pkg;

    localparam int DATA_W   = 32;
    localparam int SLOT_W   = 16;
    localparam int CFG_IDX_W = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BYTES = 2'd2;

    // reset values of the configuration registers
    localparam logic [SLOT_W-1:0] RST_SLOT_BYTES   = 16'd8;
    localparam logic [DATA_W-1:0] RST_REGION_BASE  = 32'd0;
    localparam logic [DATA_W-1:0] RST_REGION_BYTES = 32'd4096;

    // request operations
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_NOMEM = 2'd1,
        STAT_NULL  = 2'd2,
        STAT_FULL  = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_POP  = 1'b1
    } t_state;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_bytes;
        logic [DATA_W-1:0] region_base;
        logic [DATA_W-1:0] region_bytes;
    } t_cfg;

endpackage

// ===== hw/rtl/fsa_if.sv =====
// ----------------------------------------------------------------------------
// fsa_if
// Valid/ready channels of the fixed slot allocator: request, response and
// configuration write.
// ----------------------------------------------------------------------------
interface fsa_req_if;
    logic                      valid;
    logic                      ready;
    logic                      operation;
    logic [fsa_pkg::DATA_W-1:0] slot_address;

    modport source (output valid, output operation, output slot_address, input ready);
    modport sink   (input valid, input operation, input slot_address, output ready);
endinterface

interface fsa_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [fsa_pkg::DATA_W-1:0] granted_address;
    logic [1:0]                status;

    modport source (output valid, output granted_address, output status, input ready);
    modport sink   (input valid, input granted_address, input status, output ready);
endinterface

interface fsa_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [fsa_pkg::CFG_IDX_W-1:0] index;
    logic [fsa_pkg::DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/fixed_slot_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// fixed_slot_allocator_unit
// Fixed-size slot allocator with a LIFO free list and a bump pointer.
// ----------------------------------------------------------------------------
// Each request gets exactly one response. An allocate first pops the most
// recently released slot from the free list, else hands out region_base plus
// the bump offset while a whole slot still fits in the region, else answers
// out of memory. A release pushes any non-zero address; null releases and
// pushes onto a full list are reported and change nothing. The free list
// lives in a RAM with one read port and registered read data, so an allocate
// served from the free list first reads the RAM, then responds from S_POP;
// every other request is answered directly into the response register on the
// output. A new request is taken only in S_IDLE, when that register is free
// or being drained. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module fixed_slot_allocator_unit #(
    parameter int FREE_DEPTH = 1024,
    parameter int ADDR_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fsa_req_if.sink   i_req,
    fsa_rsp_if.source o_rsp,
    fsa_cfg_if.sink   i_cfg
);

    localparam int IDX_W = $clog2(FREE_DEPTH);
    localparam int CNT_W = $clog2(FREE_DEPTH + 1);
    localparam int SW    = (ADDR_WIDTH < fsa_pkg::DATA_W) ? ADDR_WIDTH : fsa_pkg::DATA_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FREE_DEPTH);

    fsa_pkg::t_cfg cfg;

    fsa_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_free_count, n_free_count;
    logic [fsa_pkg::DATA_W-1:0] r_bump, n_bump;
    logic r_out_valid, n_out_valid;
    logic [fsa_pkg::DATA_W-1:0] r_out_addr, n_out_addr;
    fsa_pkg::t_status r_out_status, n_out_status;

    logic accept;
    logic out_free;
    logic stack_hit;
    logic fits;
    logic [fsa_pkg::DATA_W:0] fresh_sum;
    logic [fsa_pkg::DATA_W-1:0] fresh_addr;
    logic [SW-1:0] rel_addr;

    logic mem_we, mem_re;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    logic [SW-1:0] mem_rdata;

    fsa_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    fsa_stack_ram #(
        .DEPTH (FREE_DEPTH),
        .WIDTH (SW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (rel_addr),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == fsa_pkg::S_IDLE) && out_free;
    assign accept      = i_req.valid && i_req.ready;

    assign stack_hit = (r_free_count != '0);
    assign fresh_sum = {1'b0, r_bump} + {{(fsa_pkg::DATA_W + 1 - fsa_pkg::SLOT_W){1'b0}},
                                        cfg.slot_bytes};
    assign fits      = (cfg.slot_bytes != '0) && (fresh_sum <= {1'b0, cfg.region_bytes});
    assign rel_addr  = i_req.slot_address[SW-1:0];

    // granted address wraps to the configured address width
    always_comb begin
        fresh_addr         = '0;
        fresh_addr[SW-1:0] = SW'(cfg.region_base + r_bump);
    end

    assign mem_waddr = r_free_count[IDX_W-1:0];
    assign mem_raddr = IDX_W'(r_free_count - CNT_W'(1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fsa_pkg::S_IDLE: begin
                if (accept && i_req.operation == fsa_pkg::OP_ALLOC && stack_hit) begin
                    n_state = fsa_pkg::S_POP;
                end
            end
            fsa_pkg::S_POP:  n_state = fsa_pkg::S_IDLE;
            default:         n_state = fsa_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_free_count = r_free_count;
        n_bump       = r_bump;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        case (r_state)
            fsa_pkg::S_IDLE: begin
                if (accept) begin
                    n_out_valid  = 1'b1;
                    n_out_addr   = '0;
                    n_out_status = fsa_pkg::STAT_OK;
                    if (i_req.operation == fsa_pkg::OP_ALLOC) begin
                        if (stack_hit) begin
                            // response follows once the read data is back
                            n_out_valid  = 1'b0;
                            mem_re       = 1'b1;
                            n_free_count = r_free_count - CNT_W'(1);
                        end else if (fits) begin
                            n_out_addr = fresh_addr;
                            n_bump     = fresh_sum[fsa_pkg::DATA_W-1:0];
                        end else begin
                            n_out_status = fsa_pkg::STAT_NOMEM;
                        end
                    end else begin
                        if (rel_addr == '0) begin
                            n_out_status = fsa_pkg::STAT_NULL;
                        end else if (r_free_count == FULL_CNT) begin
                            n_out_status = fsa_pkg::STAT_FULL;
                        end else begin
                            mem_we       = 1'b1;
                            n_free_count = r_free_count + CNT_W'(1);
                        end
                    end
                end
            end
            fsa_pkg::S_POP: begin
                n_out_valid            = 1'b1;
                n_out_addr             = '0;
                n_out_addr[SW-1:0]     = mem_rdata;
                n_out_status           = fsa_pkg::STAT_OK;
            end
            default: begin
                n_out_valid = r_out_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= fsa_pkg::S_IDLE;
            r_free_count <= '0;
            r_bump       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free_count <= n_free_count;
            r_bump       <= n_bump;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.granted_address = r_out_addr;
    assign o_rsp.status          = r_out_status;

endmodule

// ===== hw/rtl/fsa_stack_ram.sv =====
// ----------------------------------------------------------------------------
// fsa_stack_ram
// Free list storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fsa_stack_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/fsa_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// fsa_cfg_regs
// Configuration registers: slot size, region base and region size.
// ----------------------------------------------------------------------------
module fsa_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fsa_cfg_if.sink       i_cfg,
    output fsa_pkg::t_cfg o_cfg
);

    fsa_pkg::t_cfg r_cfg;
    fsa_pkg::t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                fsa_pkg::CFG_SLOT_BYTES:   n_cfg.slot_bytes   = i_cfg.data[fsa_pkg::SLOT_W-1:0];
                fsa_pkg::CFG_REGION_BASE:  n_cfg.region_base  = i_cfg.data;
                fsa_pkg::CFG_REGION_BYTES: n_cfg.region_bytes = i_cfg.data;
                default:                   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slot_bytes   <= fsa_pkg::RST_SLOT_BYTES;
            r_cfg.region_base  <= fsa_pkg::RST_REGION_BASE;
            r_cfg.region_bytes <= fsa_pkg::RST_REGION_BYTES;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
